@@ hdl/lfu_pkg.sv @@
`default_nettype none

package lfu_pkg;

    // table geometry
    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 20;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FILL_W     = $clog2(MAX_FRAMES + 1);

    // fixed field widths
    localparam int IN_PAGE_W  = 20;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = 32;
    localparam int SLOT_W     = 4;
    localparam int EVP_W      = 20;
    localparam int ACT_CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [CNT_W-1:0] SAT_MAX   = '1;
    localparam logic [CNT_W-1:0] CLOCK_INIT = CNT_W'(1);

    // one frame of the table
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [CNT_W-1:0]     count;
        logic [CNT_W-1:0]     stamp;
    } entry_t;

    // table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_t;

    // one result beat
    typedef struct packed {
        logic              page_fault;
        logic [SLOT_W-1:0] frame_slot;
        logic              evicted_valid;
        logic [EVP_W-1:0]  evicted_page;
        logic [CNT_W-1:0]  fault_total;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DELIVER
    } state_t;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ hdl/lfu_ifs.sv @@
`default_nettype none

// request channel
interface lfu_in_if;
    import lfu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IN_PAGE_W-1:0] page_number;
    logic                 last_of_run;

    modport source (output valid, output page_number, output last_of_run, input ready);
    modport sink (input valid, input page_number, input last_of_run, output ready);
endinterface

// result channel
interface lfu_out_if;
    import lfu_pkg::*;
    logic              valid;
    logic              ready;
    logic              page_fault;
    logic [SLOT_W-1:0] frame_slot;
    logic              evicted_valid;
    logic [EVP_W-1:0]  evicted_page;
    logic [CNT_W-1:0]  fault_total;

    modport source (
        output valid, output page_fault, output frame_slot, output evicted_valid,
        output evicted_page, output fault_total, input ready
    );
    modport sink (
        input valid, input page_fault, input frame_slot, input evicted_valid,
        input evicted_page, input fault_total, output ready
    );
endinterface

`default_nettype wire

@@ hdl/lfu_table.sv @@
`default_nettype none

module lfu_table
    import lfu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] rd_addr,
    output      entry_t           rd_data,
    input  wire wr_t              wr
);

    entry_t mem [MAX_FRAMES];
    entry_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/lfu_ctrl.sv @@
`default_nettype none

module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [FILL_W-1:0]    act,
    input  wire logic                 start,
    input  wire logic [IN_PAGE_W-1:0] in_page,
    input  wire logic                 in_last,
    output      logic                 idle,
    output      logic [IDX_W-1:0]     rd_addr,
    input  wire entry_t               rd_data,
    output      wr_t                  wr,
    output      res_t                 res,
    output      logic                 res_valid,
    input  wire logic                 out_free
);

    state_t                state_reg, state_next;
    logic [FILL_W-1:0]     idx_reg;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  last_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_slot_reg;
    logic [CNT_W-1:0]      hit_count_reg;
    logic [CNT_W-1:0]      best_cnt_reg;
    logic [CNT_W-1:0]      best_stamp_reg;
    logic [IDX_W-1:0]      vic_slot_reg;
    logic [PAGE_BITS-1:0]  vic_page_reg;
    logic [FILL_W-1:0]     filled_reg, filled_next;
    logic [CNT_W-1:0]      clock_reg, clock_next;
    logic [CNT_W-1:0]      faults_reg, faults_next;
    res_t                  res_reg, res_next;

    logic                  in_filled;
    logic                  in_active;
    logic                  is_match;
    logic                  is_better;
    logic                  room;
    logic [IDX_W-1:0]      slot;

    // shared compare unit: lookup match and victim ordering on the read frame
    assign in_filled = FILL_W'(cmp_idx_reg) < filled_reg;
    assign in_active = FILL_W'(cmp_idx_reg) < act;
    assign is_match  = in_filled && (rd_data.page == page_reg);
    assign is_better = (cmp_idx_reg == '0)
                    || ({rd_data.count, rd_data.stamp} < {best_cnt_reg, best_stamp_reg});

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, table write and result
    always_comb
    begin
        state_next  = state_reg;
        idle        = 1'b0;
        res_valid   = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        wr          = '0;
        filled_next = filled_reg;
        clock_next  = clock_reg;
        faults_next = faults_reg;
        res_next    = res_reg;
        room        = filled_reg < act;
        slot        = hit_reg ? hit_slot_reg : (room ? filled_reg[IDX_W-1:0] : vic_slot_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == FILL_W'(MAX_FRAMES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                wr.en         = 1'b1;
                wr.addr       = slot;
                wr.data.page  = page_reg;
                wr.data.stamp = clock_reg;
                wr.data.count = hit_reg ? sat_inc(hit_count_reg) : CNT_W'(1);
                clock_next    = sat_inc(clock_reg);
                if (!hit_reg)
                begin
                    faults_next = sat_inc(faults_reg);
                    if (room)
                    begin
                        filled_next = filled_reg + FILL_W'(1);
                    end
                end
                res_next.page_fault    = !hit_reg;
                res_next.frame_slot    = SLOT_W'(slot);
                res_next.evicted_valid = !hit_reg && !room;
                res_next.evicted_page  = (!hit_reg && !room) ? EVP_W'(vic_page_reg) : '0;
                res_next.fault_total   = hit_reg ? faults_reg : sat_inc(faults_reg);
                // end of run empties the table
                if (last_reg)
                begin
                    filled_next = '0;
                    clock_next  = CLOCK_INIT;
                    faults_next = '0;
                end
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            clock_reg   <= CLOCK_INIT;
            faults_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            filled_reg  <= filled_next;
            clock_reg   <= clock_next;
            faults_reg  <= faults_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (start && idle)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    idx_reg <= idx_reg + FILL_W'(1);
                end
                if (cmp_vld_reg && is_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        cmp_idx_reg <= rd_addr;
        if (start && idle)
        begin
            page_reg <= PAGE_BITS'(in_page);
            last_reg <= in_last;
        end
        if (cmp_vld_reg)
        begin
            if (is_match && !hit_reg)
            begin
                hit_slot_reg  <= cmp_idx_reg;
                hit_count_reg <= rd_data.count;
            end
            if (in_active && is_better)
            begin
                best_cnt_reg   <= rd_data.count;
                best_stamp_reg <= rd_data.stamp;
                vic_slot_reg   <= cmp_idx_reg;
                vic_page_reg   <= rd_data.page;
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ hdl/lfu_page_replacement.sv @@
`default_nettype none

// channel   dir  handshake      payload
// in_ch     in   valid/ready    page_number[19:0], last_of_run
// out_ch    out  valid/ready    page_fault, frame_slot[3:0], evicted_valid,
//                               evicted_page[19:0], fault_total[31:0]
// cfg       in   cfg_wr_en      cfg_wr_data[4:0] (frames_in_use)
//
// each item runs a scan of the frame table through its single read port, a
// drain step for the last read, an update step, a deliver step that hands the
// result to the output register, and back to idle, where the next is taken.
// rst_n clears the sequencer, fill count and fault total and sets the use
// clock to one; unfilled frames are read but never match or become victims.
// a stalled output beat holds in the output register; the next item is taken
// meanwhile and waits in the deliver step until the register frees.

module lfu_page_replacement
    import lfu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    lfu_in_if.sink                in_ch,
    lfu_out_if.source             out_ch
);

    logic [CFG_W-1:0]  cfg_reg;
    logic [FILL_W-1:0] act;
    logic              idle;
    logic              start;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    wr_t               wr;
    res_t              res;
    logic              res_valid;
    logic              out_free;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    // frames_in_use register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // active frame count, zero acts as one and excess clips to the table size
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            act = FILL_W'(1);
        end
        else if (ACT_CMP_W'(cfg_reg) > ACT_CMP_W'(MAX_FRAMES))
        begin
            act = FILL_W'(MAX_FRAMES);
        end
        else
        begin
            act = FILL_W'(cfg_reg);
        end
    end

    assign in_ch.ready = idle;
    assign start       = in_ch.valid && idle;

    lfu_table u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .act       (act),
        .start     (start),
        .in_page   (in_ch.page_number),
        .in_last   (in_ch.last_of_run),
        .idle      (idle),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr),
        .res       (res),
        .res_valid (res_valid),
        .out_free  (out_free)
    );

    // output register
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        if (res_valid && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.page_fault    = out_res_reg.page_fault;
    assign out_ch.frame_slot    = out_res_reg.frame_slot;
    assign out_ch.evicted_valid = out_res_reg.evicted_valid;
    assign out_ch.evicted_page  = out_res_reg.evicted_page;
    assign out_ch.fault_total   = out_res_reg.fault_total;

endmodule

`default_nettype wire
